// File: design/rtst_pkg.sv
package rtst_pkg;

    // Default build parameters.
    localparam int CAPACITY_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // Value that marks an empty slot of the tree.
    localparam int EMPTY_SLOT = -222222;

    // Element count register.
    localparam int              CNT_W     = 11;
    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    // Fixed field widths of the stream payloads.
    localparam int POS_W     = 10;
    localparam int DIN_W     = 32;
    localparam int SUM_W     = 33;
    localparam int VAL_OUT_W = 32;

    // Input tdata layout, lowest bit first.
    localparam int S_TDATA_W  = 64;
    localparam int S_POS_LSB  = 0;
    localparam int S_VAL_LSB  = S_POS_LSB + POS_W;
    localparam int S_LOW_LSB  = S_VAL_LSB + DIN_W;
    localparam int S_HIGH_LSB = S_LOW_LSB + POS_W;

    // Output tdata layout, lowest bit first.
    localparam int M_TDATA_W = 104;
    localparam int M_SUM_LSB = 0;
    localparam int M_TOP_LSB = M_SUM_LSB + SUM_W;
    localparam int M_SEC_LSB = M_TOP_LSB + VAL_OUT_W;
    localparam int M_USED_W  = M_SEC_LSB + VAL_OUT_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_U_DESC,
        ST_U_UP,
        ST_U_MRG,
        ST_Q_VISIT,
        ST_Q_READ,
        ST_Q_MERGE,
        ST_Q_OUT
    } t_state;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_DESCEND,
        DP_LEAF,
        DP_SIB_RD,
        DP_UP_MERGE,
        DP_NODE_RD,
        DP_EMPTY,
        DP_SPLIT,
        DP_TAKE,
        DP_POP_MERGE,
        DP_PUSH_POP,
        DP_EMIT
    } t_dp_op;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic clear_last;
        logic op_query;
        logic pos_ok;
        logic range_bad;
        logic leaf;
        logic at_root;
        logic covered;
        logic disjoint;
        logic frames_empty;
        logic merges_zero;
        logic out_free;
    } t_sts;

endpackage

// File: design/rtst_ram.sv
module rtst_ram #(
    parameter int WIDTH = 2 * rtst_pkg::VALUE_BITS_DEF,
    parameter int DEPTH = 4 * rtst_pkg::CAPACITY_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/rtst_ctrl.sv
module rtst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rtst_pkg::t_sts    i_sts,
    output rtst_pkg::t_dp_op  o_op
);

    rtst_pkg::t_state r_state;
    rtst_pkg::t_state n_state;
    logic             accept;

    assign accept = i_in_valid && (r_state == rtst_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtst_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rtst_pkg::ST_CLEAR: begin
                if (i_sts.clear_last) n_state = rtst_pkg::ST_IDLE;
            end
            rtst_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_sts.op_query) begin
                        n_state = i_sts.range_bad ? rtst_pkg::ST_Q_OUT : rtst_pkg::ST_Q_VISIT;
                    end else if (i_sts.pos_ok) begin
                        n_state = rtst_pkg::ST_U_DESC;
                    end
                end
            end
            rtst_pkg::ST_U_DESC: begin
                if (i_sts.leaf) n_state = rtst_pkg::ST_U_UP;
            end
            rtst_pkg::ST_U_UP: begin
                n_state = i_sts.at_root ? rtst_pkg::ST_IDLE : rtst_pkg::ST_U_MRG;
            end
            rtst_pkg::ST_U_MRG: begin
                n_state = rtst_pkg::ST_U_UP;
            end
            rtst_pkg::ST_Q_VISIT: begin
                if (i_sts.covered) begin
                    n_state = rtst_pkg::ST_Q_READ;
                end else if (i_sts.disjoint) begin
                    n_state = rtst_pkg::ST_Q_MERGE;
                end
            end
            rtst_pkg::ST_Q_READ: begin
                n_state = rtst_pkg::ST_Q_MERGE;
            end
            rtst_pkg::ST_Q_MERGE: begin
                if (i_sts.merges_zero) begin
                    n_state = i_sts.frames_empty ? rtst_pkg::ST_Q_OUT : rtst_pkg::ST_Q_VISIT;
                end
            end
            rtst_pkg::ST_Q_OUT: begin
                if (i_sts.out_free) n_state = rtst_pkg::ST_IDLE;
            end
            default: n_state = rtst_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == rtst_pkg::ST_IDLE);
        o_op       = rtst_pkg::DP_NOP;
        unique case (r_state)
            rtst_pkg::ST_CLEAR: o_op = rtst_pkg::DP_CLEAR;
            rtst_pkg::ST_IDLE: begin
                if (accept) o_op = rtst_pkg::DP_LOAD;
            end
            rtst_pkg::ST_U_DESC: begin
                o_op = i_sts.leaf ? rtst_pkg::DP_LEAF : rtst_pkg::DP_DESCEND;
            end
            rtst_pkg::ST_U_UP: begin
                if (!i_sts.at_root) o_op = rtst_pkg::DP_SIB_RD;
            end
            rtst_pkg::ST_U_MRG: o_op = rtst_pkg::DP_UP_MERGE;
            rtst_pkg::ST_Q_VISIT: begin
                priority if (i_sts.covered) begin
                    o_op = rtst_pkg::DP_NODE_RD;
                end else if (i_sts.disjoint) begin
                    o_op = rtst_pkg::DP_EMPTY;
                end else begin
                    o_op = rtst_pkg::DP_SPLIT;
                end
            end
            rtst_pkg::ST_Q_READ: o_op = rtst_pkg::DP_TAKE;
            rtst_pkg::ST_Q_MERGE: begin
                if (!i_sts.merges_zero) begin
                    o_op = rtst_pkg::DP_POP_MERGE;
                end else if (!i_sts.frames_empty) begin
                    o_op = rtst_pkg::DP_PUSH_POP;
                end
            end
            rtst_pkg::ST_Q_OUT: begin
                if (i_sts.out_free) o_op = rtst_pkg::DP_EMIT;
            end
            default: o_op = rtst_pkg::DP_NOP;
        endcase
    end

endmodule

// File: design/rtst_dp.sv
module rtst_dp #(
    parameter int CAPACITY   = rtst_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = rtst_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rtst_pkg::t_dp_op                    i_op,
    output rtst_pkg::t_sts                      o_sts,
    input  logic                                i_cfg_wr_en,
    input  logic [rtst_pkg::CNT_W-1:0]          i_cfg_wr_data,
    input  logic                                i_operation,
    input  logic [rtst_pkg::POS_W-1:0]          i_position,
    input  logic [rtst_pkg::DIN_W-1:0]          i_new_value,
    input  logic [rtst_pkg::POS_W-1:0]          i_range_low,
    input  logic [rtst_pkg::POS_W-1:0]          i_range_high,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [rtst_pkg::SUM_W-1:0]          o_pair_sum,
    output logic [rtst_pkg::VAL_OUT_W-1:0]      o_top_value,
    output logic [rtst_pkg::VAL_OUT_W-1:0]      o_second_value,
    output logic                                o_range_error
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int SPAN_W  = (rtst_pkg::CNT_W > IDX_W + 1) ? rtst_pkg::CNT_W : IDX_W + 1;
    localparam int DEPTH   = 4 * CAPACITY;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int STORE_W = (VALUE_BITS > 19) ? VALUE_BITS : 19;
    localparam int IN_W    = (VALUE_BITS < rtst_pkg::DIN_W) ? VALUE_BITS : rtst_pkg::DIN_W;
    localparam int OUT_W   = (STORE_W + 1 > rtst_pkg::SUM_W) ? STORE_W + 1 : rtst_pkg::SUM_W;
    localparam int LEVELS  = IDX_W + 1;
    localparam int FI_W    = $clog2(LEVELS);
    localparam int FP_W    = $clog2(LEVELS + 1);
    localparam int MRG_W   = $clog2(LEVELS + 1);

    localparam logic signed [STORE_W-1:0] EMPTY = STORE_W'(rtst_pkg::EMPTY_SLOT);

    // Configuration and control registers.
    logic [rtst_pkg::CNT_W-1:0] r_count;
    logic [ADDR_W-1:0]          r_clr_addr;
    logic [FP_W-1:0]            r_fsp;
    logic [FP_W-1:0]            r_vsp;
    logic                       r_o_valid;

    // Current tree node and item operands.
    logic [SPAN_W-1:0]          r_lo;
    logic [SPAN_W-1:0]          r_hi;
    logic [ADDR_W-1:0]          r_si;
    logic [MRG_W-1:0]           r_cur_m;
    logic [MRG_W-1:0]           r_mcnt;
    logic [SPAN_W-1:0]          r_pos;
    logic [SPAN_W-1:0]          r_qs;
    logic [SPAN_W-1:0]          r_qe;
    logic signed [STORE_W-1:0]  r_val;
    logic                       r_err;
    logic signed [STORE_W-1:0]  r_acc_top;
    logic signed [STORE_W-1:0]  r_acc_sec;

    // Pending right-hand frames and partial results of a query.
    logic [SPAN_W-1:0]          r_f_lo  [LEVELS];
    logic [SPAN_W-1:0]          r_f_hi  [LEVELS];
    logic [ADDR_W-1:0]          r_f_si  [LEVELS];
    logic [MRG_W-1:0]           r_f_m   [LEVELS];
    logic signed [STORE_W-1:0]  r_v_top [LEVELS];
    logic signed [STORE_W-1:0]  r_v_sec [LEVELS];

    // Output register.
    logic [rtst_pkg::SUM_W-1:0]     r_o_sum;
    logic [rtst_pkg::VAL_OUT_W-1:0] r_o_top;
    logic [rtst_pkg::VAL_OUT_W-1:0] r_o_sec;
    logic                           r_o_err;

    logic [IN_W-1:0]            val_bits;
    logic signed [STORE_W-1:0]  val_ext;
    logic [SPAN_W-1:0]          cnt_ext;
    logic [SPAN_W-1:0]          last_idx;
    logic [SPAN_W-1:0]          pos_in;
    logic [SPAN_W-1:0]          qs_in;
    logic [SPAN_W-1:0]          qe_in;
    logic [SPAN_W:0]            mid_sum;
    logic [SPAN_W-1:0]          mid;
    logic [SPAN_W-1:0]          mid_p1;
    logic [ADDR_W-1:0]          child_l;
    logic [ADDR_W-1:0]          child_r;
    logic [ADDR_W-1:0]          si_dec;
    logic [ADDR_W-1:0]          parent;
    logic [ADDR_W-1:0]          sibling;
    logic [FP_W-1:0]            fsp_dec;
    logic [FP_W-1:0]            vsp_dec;
    logic [FI_W-1:0]            f_top_idx;
    logic [FI_W-1:0]            f_push_idx;
    logic [FI_W-1:0]            v_top_idx;
    logic [FI_W-1:0]            v_push_idx;

    logic [2*STORE_W-1:0]       rd_data;
    logic signed [STORE_W-1:0]  ram_top;
    logic signed [STORE_W-1:0]  ram_sec;
    logic                       ram_wr_en;
    logic [ADDR_W-1:0]          ram_wr_addr;
    logic [2*STORE_W-1:0]       ram_wr_data;
    logic                       ram_rd_en;
    logic [ADDR_W-1:0]          ram_rd_addr;

    logic signed [STORE_W-1:0]  mrg_l_top;
    logic signed [STORE_W-1:0]  mrg_l_sec;
    logic signed [STORE_W-1:0]  mrg_r_top;
    logic signed [STORE_W-1:0]  mrg_r_sec;
    logic signed [STORE_W-1:0]  mrg_top;
    logic signed [STORE_W-1:0]  mrg_sec;

    logic signed [OUT_W-1:0]    top_w;
    logic signed [OUT_W-1:0]    sec_w;
    logic signed [OUT_W-1:0]    sum_w;

    // Input value, sign-extended from the value width; zero-extended if that exceeds DIN_W.
    assign val_bits = i_new_value[IN_W-1:0];

    always_comb begin
        if (VALUE_BITS <= rtst_pkg::DIN_W) begin
            val_ext = STORE_W'($signed(val_bits));
        end else begin
            val_ext = STORE_W'(val_bits);
        end
    end

    // Last usable index: a count of zero acts as one, a count above capacity as capacity.
    assign cnt_ext = SPAN_W'(r_count);

    always_comb begin
        if (r_count == '0) begin
            last_idx = '0;
        end else if (cnt_ext > SPAN_W'(CAPACITY)) begin
            last_idx = SPAN_W'(CAPACITY - 1);
        end else begin
            last_idx = cnt_ext - SPAN_W'(1);
        end
    end

    assign pos_in = SPAN_W'(i_position);
    assign qs_in  = SPAN_W'(i_range_low);
    assign qe_in  = SPAN_W'(i_range_high);

    // Node arithmetic.
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[SPAN_W:1];
    assign mid_p1  = mid + SPAN_W'(1);
    assign child_l = ADDR_W'({r_si, 1'b1});
    assign child_r = child_l + ADDR_W'(1);
    assign si_dec  = r_si - ADDR_W'(1);
    assign parent  = {1'b0, si_dec[ADDR_W-1:1]};
    assign sibling = r_si[0] ? (r_si + ADDR_W'(1)) : si_dec;

    assign fsp_dec    = r_fsp - FP_W'(1);
    assign vsp_dec    = r_vsp - FP_W'(1);
    assign f_top_idx  = fsp_dec[FI_W-1:0];
    assign f_push_idx = r_fsp[FI_W-1:0];
    assign v_top_idx  = vsp_dec[FI_W-1:0];
    assign v_push_idx = r_vsp[FI_W-1:0];

    assign ram_top = $signed(rd_data[2*STORE_W-1:STORE_W]);
    assign ram_sec = $signed(rd_data[STORE_W-1:0]);

    // Shared merge unit; on a tie of the tops the right side wins.
    always_comb begin
        if (i_op == rtst_pkg::DP_POP_MERGE) begin
            mrg_l_top = r_v_top[v_top_idx];
            mrg_l_sec = r_v_sec[v_top_idx];
            mrg_r_top = r_acc_top;
            mrg_r_sec = r_acc_sec;
        end else if (r_si[0]) begin
            mrg_l_top = r_acc_top;
            mrg_l_sec = r_acc_sec;
            mrg_r_top = ram_top;
            mrg_r_sec = ram_sec;
        end else begin
            mrg_l_top = ram_top;
            mrg_l_sec = ram_sec;
            mrg_r_top = r_acc_top;
            mrg_r_sec = r_acc_sec;
        end
    end

    always_comb begin
        if (mrg_l_top > mrg_r_top) begin
            mrg_top = mrg_l_top;
            mrg_sec = (mrg_l_sec > mrg_r_top) ? mrg_l_sec : mrg_r_top;
        end else begin
            mrg_top = mrg_r_top;
            mrg_sec = (mrg_r_sec > mrg_l_top) ? mrg_r_sec : mrg_l_top;
        end
    end

    // Node store port control.
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = parent;
        ram_wr_data = {mrg_top, mrg_sec};
        unique case (i_op)
            rtst_pkg::DP_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_addr;
                ram_wr_data = {EMPTY, EMPTY};
            end
            rtst_pkg::DP_LEAF: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_si;
                ram_wr_data = {r_val, EMPTY};
            end
            rtst_pkg::DP_UP_MERGE: begin
                ram_wr_en = 1'b1;
            end
            default: ram_wr_en = 1'b0;
        endcase
    end

    assign ram_rd_en   = (i_op == rtst_pkg::DP_SIB_RD) || (i_op == rtst_pkg::DP_NODE_RD);
    assign ram_rd_addr = (i_op == rtst_pkg::DP_SIB_RD) ? sibling : r_si;

    rtst_ram #(
        .WIDTH (2 * STORE_W),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (rd_data)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= rtst_pkg::CNT_RESET;
            r_clr_addr <= '0;
            r_fsp      <= '0;
            r_vsp      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
            unique case (i_op)
                rtst_pkg::DP_CLEAR:     r_clr_addr <= r_clr_addr + ADDR_W'(1);
                rtst_pkg::DP_LOAD: begin
                    r_fsp <= '0;
                    r_vsp <= '0;
                end
                rtst_pkg::DP_SPLIT:     r_fsp <= r_fsp + FP_W'(1);
                rtst_pkg::DP_POP_MERGE: r_vsp <= vsp_dec;
                rtst_pkg::DP_PUSH_POP: begin
                    r_vsp <= r_vsp + FP_W'(1);
                    r_fsp <= fsp_dec;
                end
                default: ;
            endcase
            if (i_op == rtst_pkg::DP_EMIT) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Sign-extended view of the result for the output fields.
    assign top_w = OUT_W'(r_acc_top);
    assign sec_w = OUT_W'(r_acc_sec);
    assign sum_w = top_w + sec_w;

    // Payload registers.
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            rtst_pkg::DP_LOAD: begin
                r_lo    <= '0;
                r_hi    <= last_idx;
                r_si    <= '0;
                r_cur_m <= '0;
                r_pos   <= pos_in;
                r_qs    <= qs_in;
                r_qe    <= qe_in;
                r_val   <= val_ext;
                r_err   <= (qs_in > qe_in) || (qe_in > last_idx);
            end
            rtst_pkg::DP_DESCEND: begin
                if (r_pos <= mid) begin
                    r_hi <= mid;
                    r_si <= child_l;
                end else begin
                    r_lo <= mid_p1;
                    r_si <= child_r;
                end
            end
            rtst_pkg::DP_LEAF: begin
                r_acc_top <= r_val;
                r_acc_sec <= EMPTY;
            end
            rtst_pkg::DP_UP_MERGE: begin
                r_acc_top <= mrg_top;
                r_acc_sec <= mrg_sec;
                r_si      <= parent;
            end
            rtst_pkg::DP_NODE_RD: begin
                r_mcnt <= r_cur_m;
            end
            rtst_pkg::DP_EMPTY: begin
                r_acc_top <= EMPTY;
                r_acc_sec <= EMPTY;
                r_mcnt    <= r_cur_m;
            end
            rtst_pkg::DP_SPLIT: begin
                r_f_lo[f_push_idx] <= mid_p1;
                r_f_hi[f_push_idx] <= r_hi;
                r_f_si[f_push_idx] <= child_r;
                r_f_m[f_push_idx]  <= r_cur_m + MRG_W'(1);
                r_hi               <= mid;
                r_si               <= child_l;
                r_cur_m            <= '0;
            end
            rtst_pkg::DP_TAKE: begin
                r_acc_top <= ram_top;
                r_acc_sec <= ram_sec;
            end
            rtst_pkg::DP_POP_MERGE: begin
                r_acc_top <= mrg_top;
                r_acc_sec <= mrg_sec;
                r_mcnt    <= r_mcnt - MRG_W'(1);
            end
            rtst_pkg::DP_PUSH_POP: begin
                r_v_top[v_push_idx] <= r_acc_top;
                r_v_sec[v_push_idx] <= r_acc_sec;
                r_lo                <= r_f_lo[f_top_idx];
                r_hi                <= r_f_hi[f_top_idx];
                r_si                <= r_f_si[f_top_idx];
                r_cur_m             <= r_f_m[f_top_idx];
            end
            rtst_pkg::DP_EMIT: begin
                if (r_err) begin
                    r_o_sum <= '0;
                    r_o_top <= '0;
                    r_o_sec <= '0;
                end else begin
                    r_o_sum <= sum_w[rtst_pkg::SUM_W-1:0];
                    r_o_top <= top_w[rtst_pkg::VAL_OUT_W-1:0];
                    r_o_sec <= sec_w[rtst_pkg::VAL_OUT_W-1:0];
                end
                r_o_err <= r_err;
            end
            default: ;
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_sts.clear_last   = (r_clr_addr == ADDR_W'(DEPTH - 1));
        o_sts.op_query     = i_operation;
        o_sts.pos_ok       = (pos_in <= last_idx);
        o_sts.range_bad    = (qs_in > qe_in) || (qe_in > last_idx);
        o_sts.leaf         = (r_lo == r_hi);
        o_sts.at_root      = (r_si == '0);
        o_sts.covered      = (r_qs <= r_lo) && (r_qe >= r_hi);
        o_sts.disjoint     = (r_hi < r_qs) || (r_lo > r_qe);
        o_sts.frames_empty = (r_fsp == '0);
        o_sts.merges_zero  = (r_mcnt == '0);
        o_sts.out_free     = !r_o_valid || i_out_ready;
    end

    assign o_out_valid    = r_o_valid;
    assign o_pair_sum     = r_o_sum;
    assign o_top_value    = r_o_top;
    assign o_second_value = r_o_sec;
    assign o_range_error  = r_o_err;

endmodule

// File: design/range_top_two_sum_tree_core.sv
// An update walks down level by level to the leaf and writes it, then reads the sibling and
// writes the merged parent at each level back up. A query splits each node that straddles its
// range, reads whole each node inside it and skips each node outside it, then emits the result;
// a bad range goes straight to the result, an update outside the count is dropped, and a
// stalled result holds the query until the output is free. One item at a time. After reset a
// clearing pass over all 4*CAPACITY node slots holds s_axis_tready low.
module range_top_two_sum_tree_core #(
    parameter int CAPACITY   = rtst_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = rtst_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // Configuration: element_count, written whenever the write enable is high.
    input  logic                              i_cfg_wr_en,
    input  logic [rtst_pkg::CNT_W-1:0]        i_cfg_wr_data,

    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // position[9:0], new_value[41:10], range_low[51:42], range_high[61:52], zero pad[63:62]
    input  logic [rtst_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // operation[0]: 0 = point update, 1 = range query
    input  logic [0:0]                        s_axis_tuser,

    // Result stream, one transaction per query.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pair_sum[32:0], top_value[64:33], second_value[96:65], zero pad[103:97]
    output logic [rtst_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // range_error[0]
    output logic [0:0]                        m_axis_tuser
);

    rtst_pkg::t_dp_op op;
    rtst_pkg::t_sts   sts;

    logic [rtst_pkg::POS_W-1:0]     position;
    logic [rtst_pkg::DIN_W-1:0]     new_value;
    logic [rtst_pkg::POS_W-1:0]     range_low;
    logic [rtst_pkg::POS_W-1:0]     range_high;
    logic [rtst_pkg::SUM_W-1:0]     pair_sum;
    logic [rtst_pkg::VAL_OUT_W-1:0] top_value;
    logic [rtst_pkg::VAL_OUT_W-1:0] second_value;
    logic                           range_error;

    // Unpack the input transaction.
    assign position   = s_axis_tdata[rtst_pkg::S_POS_LSB  +: rtst_pkg::POS_W];
    assign new_value  = s_axis_tdata[rtst_pkg::S_VAL_LSB  +: rtst_pkg::DIN_W];
    assign range_low  = s_axis_tdata[rtst_pkg::S_LOW_LSB  +: rtst_pkg::POS_W];
    assign range_high = s_axis_tdata[rtst_pkg::S_HIGH_LSB +: rtst_pkg::POS_W];

    // The controller sequences descents, merges and the query traversal; the datapath
    // owns the node memory, the current node, the frame and value stacks and the
    // output register, which lets a new item in while a result is still waiting.
    rtst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_op       (op)
    );

    rtst_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .o_sts          (sts),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_operation    (s_axis_tuser[0]),
        .i_position     (position),
        .i_new_value    (new_value),
        .i_range_low    (range_low),
        .i_range_high   (range_high),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_pair_sum     (pair_sum),
        .o_top_value    (top_value),
        .o_second_value (second_value),
        .o_range_error  (range_error)
    );

    // Pack the result transaction.
    assign m_axis_tdata = {{(rtst_pkg::M_TDATA_W - rtst_pkg::M_USED_W){1'b0}},
                           second_value, top_value, pair_sum};
    assign m_axis_tuser = range_error;

endmodule

// File: test/range_top_two_sum_tree_core_tb.sv
`timescale 1ns / 1ps

// Testbench for the range top-two segment tree core.
//
// The bench keeps its own copy of the tree (top and second value per node) and
// of the element count. Every input transaction that the core accepts is
// replayed on that copy at the same clock edge. Updates change the copy, and
// queries push the answer they should produce. Each output transaction is
// compared field by field against the oldest pending answer.
//
// The run is a chain of test tasks called from one initial block:
//   - queries over unwritten leaves, extreme values, equal tops and a reversed
//     range, all under the reset count of 1024,
//   - the count register at its edges: 0 (taken as 1), 2047 (taken as 1024),
//     updates beyond the count and ranges that run past it,
//   - random phases with different counts and idling patterns,
//   - a long output hold-off that fills the core and stalls its input.
// The count is only rewritten once every pending answer has arrived and the
// core has had time to finish a trailing update.
module range_top_two_sum_tree_core_tb;
    import rtst_pkg::*;

    localparam int  CLK_PERIOD   = 4;
    localparam int  RESET_CYCLES = 6;
    // An update makes no output transaction, so the core may still be busy
    // with one once the last pending answer has come back; this wait covers
    // that tail.
    localparam int  DRAIN_CYCLES = 200;
    localparam int  NODE_SLOTS   = 4 * CAPACITY_DEF;
    localparam logic OP_UPDATE   = 1'b0;
    localparam logic OP_QUERY    = 1'b1;

    typedef struct packed {
        int top;
        int second;
    } t_top_two;

    typedef struct packed {
        logic [SUM_W-1:0]     pair_sum;
        logic [VAL_OUT_W-1:0] top;
        logic [VAL_OUT_W-1:0] second;
        logic                 range_error;
    } t_range_answer;

    // Every input of the core has a known value from time zero.
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]     i_cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [0:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]           m_axis_tuser;

    // Shadow copy of the tree and of the count register.
    int               shadow_top [NODE_SLOTS];
    int               shadow_second [NODE_SLOTS];
    logic [CNT_W-1:0] shadow_count;
    t_range_answer    pending_answers [$];

    // Idling controls for the sender and the receiver.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    int mismatches  = 0;
    int n_updates   = 0;
    int n_queries   = 0;
    int n_bad_range = 0;
    int n_checked   = 0;

    range_top_two_sum_tree_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow tree
    // ------------------------------------------------------------------

    // A count of 0 acts as 1 and anything above the capacity as the capacity.
    function automatic int effective_count();
        if (shadow_count < 1)
            return 1;
        if (shadow_count > CAPACITY_DEF)
            return CAPACITY_DEF;
        return int'(shadow_count);
    endfunction

    // The left child wins only on a strictly greater top, so ties go right.
    function automatic t_top_two merge_pair(t_top_two l, t_top_two r);
        t_top_two m;
        if (l.top > r.top) begin
            m.top    = l.top;
            m.second = (l.second > r.top) ? l.second : r.top;
        end else begin
            m.top    = r.top;
            m.second = (r.second > l.top) ? r.second : l.top;
        end
        return m;
    endfunction

    function automatic t_top_two read_shadow(int si);
        t_top_two p;
        if (si >= NODE_SLOTS) begin
            p.top    = EMPTY_SLOT;
            p.second = EMPTY_SLOT;
        end else begin
            p.top    = shadow_top[si];
            p.second = shadow_second[si];
        end
        return p;
    endfunction

    // Writes one leaf and rebuilds its ancestors on the way back up.
    function automatic void store_leaf(int lo, int hi, int si, int pos, int val);
        int       mid;
        t_top_two p;
        if (si >= NODE_SLOTS)
            return;
        if (lo == hi) begin
            shadow_top[si]    = val;
            shadow_second[si] = EMPTY_SLOT;
            return;
        end
        mid = (lo + hi) / 2;
        if (pos <= mid)
            store_leaf(lo, mid, 2 * si + 1, pos, val);
        else
            store_leaf(mid + 1, hi, 2 * si + 2, pos, val);
        p = merge_pair(read_shadow(2 * si + 1), read_shadow(2 * si + 2));
        shadow_top[si]    = p.top;
        shadow_second[si] = p.second;
    endfunction

    // Merges the nodes that cover [qs, qe] below node si.
    function automatic t_top_two range_top_two(int lo, int hi, int qs, int qe, int si);
        int       mid;
        t_top_two none;
        none.top    = EMPTY_SLOT;
        none.second = EMPTY_SLOT;
        if (qs <= lo && qe >= hi)
            return read_shadow(si);
        if (hi < qs || lo > qe || si >= NODE_SLOTS)
            return none;
        mid = (lo + hi) / 2;
        return merge_pair(range_top_two(lo, mid, qs, qe, 2 * si + 1),
                          range_top_two(mid + 1, hi, qs, qe, 2 * si + 2));
    endfunction

    // Applies one accepted input transaction to the shadow tree and, for a
    // query, queues the answer the core has to return.
    function automatic void apply_and_predict(logic op, logic [POS_W-1:0] pos,
                                              logic [DIN_W-1:0] val,
                                              logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
        int            n;
        t_top_two      r;
        longint        sum;
        t_range_answer ans;
        n = effective_count();
        if (op == OP_UPDATE) begin
            n_updates++;
            if (int'(pos) < n)
                store_leaf(0, n - 1, 0, int'(pos), int'(val));
            return;
        end
        n_queries++;
        ans = '0;
        if (lo > hi || int'(hi) >= n) begin
            // A bad range returns zero values with the error flag set.
            ans.range_error = 1'b1;
            n_bad_range++;
        end else begin
            r   = range_top_two(0, n - 1, int'(lo), int'(hi), 0);
            sum = longint'(r.top) + longint'(r.second);
            ans.pair_sum = sum[SUM_W-1:0];
            ans.top      = r.top;
            ans.second   = r.second;
        end
        pending_answers.push_back(ans);
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one transaction and returns at the edge where it is accepted.
    // The valid is left high so that the next call can follow back to back;
    // stop_sending lowers it when the stimulus pauses.
    task automatic send_item(input logic op, input logic [POS_W-1:0] pos,
                             input logic [DIN_W-1:0] val,
                             input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[S_POS_LSB  +: POS_W] = pos;
        word[S_VAL_LSB  +: DIN_W] = val;
        word[S_LOW_LSB  +: POS_W] = lo;
        word[S_HIGH_LSB +: POS_W] = hi;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        apply_and_predict(op, pos, val, lo, hi);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    // Waits for every pending answer plus the tail of a possible update.
    task automatic wait_idle();
        stop_sending();
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Rewrites the count register while the core is idle.
    task automatic set_element_count(input logic [CNT_W-1:0] count);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= count;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        shadow_count = count;
    endtask

    // Values lean toward the extremes, the empty marker and small numbers
    // that give equal tops.
    function automatic logic [DIN_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'(EMPTY_SLOT);
            3, 4:    return 32'($urandom_range(0, 6) - 3);
            default: return $urandom;
        endcase
    endfunction

    // Mostly updates inside the count and well-formed query ranges; the rest
    // are stray positions and arbitrary ranges.
    task automatic send_random_item();
        int               n;
        int               lo;
        int               hi;
        logic [POS_W-1:0] pos;
        n = effective_count();
        if ($urandom_range(0, 99) < 55) begin
            if ($urandom_range(0, 9) == 0)
                pos = POS_W'($urandom_range(0, 1023));
            else
                pos = POS_W'($urandom_range(0, n - 1));
            send_item(OP_UPDATE, pos, pick_value(), POS_W'($urandom), POS_W'($urandom));
        end else begin
            if ($urandom_range(0, 99) < 15) begin
                lo = $urandom_range(0, 1023);
                hi = $urandom_range(0, 1023);
            end else begin
                lo = $urandom_range(0, n - 1);
                case ($urandom_range(0, 3))
                    0:       hi = lo;
                    1:       hi = (lo + 7 < n) ? lo + $urandom_range(0, 7) : n - 1;
                    default: hi = $urandom_range(lo, n - 1);
                endcase
            end
            send_item(OP_QUERY, POS_W'($urandom), $urandom, POS_W'(lo), POS_W'(hi));
        end
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // The receiver stalls at random, or holds off for a counted stretch when
    // a test asks for one.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Every output transaction is matched against the oldest pending answer.
    always @(posedge i_clk) begin
        t_range_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t ns: output transaction with no query pending, tdata %h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                n_checked++;
                check_field("pair_sum", longint'($signed(want.pair_sum)),
                            longint'($signed(m_axis_tdata[M_SUM_LSB +: SUM_W])));
                check_field("top_value", longint'($signed(want.top)),
                            longint'($signed(m_axis_tdata[M_TOP_LSB +: VAL_OUT_W])));
                check_field("second_value", longint'($signed(want.second)),
                            longint'($signed(m_axis_tdata[M_SEC_LSB +: VAL_OUT_W])));
                check_field("range_error", longint'(want.range_error),
                            longint'(m_axis_tuser[0]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Unwritten leaves, the most negative and most positive values, the empty
    // marker as data, equal tops on both sides of the middle and a reversed
    // range, all at the reset count.
    task automatic test_directed_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(OP_QUERY,  '0,       '0,           10'd0,    10'd1023);
        send_item(OP_QUERY,  '0,       '0,           10'd5,    10'd5);
        send_item(OP_UPDATE, 10'd0,    32'h8000_0000, '0,      '0);
        send_item(OP_UPDATE, 10'd1023, 32'h7FFF_FFFF, '1,      '1);
        send_item(OP_QUERY,  '1,       '1,           10'd0,    10'd1023);
        send_item(OP_UPDATE, 10'd1,    32'h7FFF_FFFF, '0,      '0);
        send_item(OP_QUERY,  '0,       '0,           10'd0,    10'd1023);
        send_item(OP_UPDATE, 10'd2,    32'(EMPTY_SLOT), '0,    '0);
        send_item(OP_QUERY,  '0,       '0,           10'd0,    10'd2);
        send_item(OP_QUERY,  '0,       '0,           10'd10,   10'd3);
        send_item(OP_QUERY,  '0,       '0,           10'd1023, 10'd1023);
        send_item(OP_UPDATE, 10'd511,  32'd7,        '0,       '0);
        send_item(OP_UPDATE, 10'd512,  32'd7,        '0,       '0);
        send_item(OP_QUERY,  '0,       '0,           10'd500,  10'd520);
        send_item(OP_QUERY,  '0,       '0,           10'd0,    10'd0);
    endtask

    // Count 0 acts as 1, so position 1 and a range up to 1 fall outside it.
    // Going back to the full size reads the store under the new tree shape.
    task automatic test_count_limits();
        set_element_count(11'd0);
        send_item(OP_QUERY,  '0,       '0,     10'd0, 10'd0);
        send_item(OP_QUERY,  '0,       '0,     10'd0, 10'd1);
        send_item(OP_UPDATE, 10'd1,    32'd5,  '0,    '0);
        send_item(OP_UPDATE, 10'd1023, 32'd9,  '0,    '0);
        send_item(OP_UPDATE, 10'd0,    32'd123, '0,   '0);
        send_item(OP_QUERY,  '0,       '0,     10'd0, 10'd0);
        set_element_count(11'd2047);
        send_item(OP_QUERY,  '0,       '0,     10'd0, 10'd1023);
        send_item(OP_QUERY,  '0,       '0,     10'd0, 10'd511);
    endtask

    task automatic test_random_phase(input logic [CNT_W-1:0] count, input int send_pct,
                                     input int recv_pct, input int items);
        set_element_count(count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (items) send_random_item();
    endtask

    // The receiver holds off long enough for the core to fill up while the
    // sender keeps offering queries, so the input stalls too.
    task automatic test_output_backpressure();
        set_element_count(11'd64);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 3000;
        repeat (40)
            send_item(OP_QUERY, POS_W'($urandom), $urandom, 10'd0, POS_W'($urandom_range(0, 63)));
    endtask

    initial begin
        for (int i = 0; i < NODE_SLOTS; i++) begin
            shadow_top[i]    = EMPTY_SLOT;
            shadow_second[i] = EMPTY_SLOT;
        end
        shadow_count = CNT_RESET;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first transaction waits out the clearing pass after reset.
        test_directed_extremes();
        test_count_limits();
        test_random_phase(11'd1024, 0,  0,  400);
        test_random_phase(11'd16,   83, 0,  300);
        test_random_phase(11'd2047, 0,  83, 300);
        test_random_phase(11'd100,  7,  7,  300);
        test_random_phase(CNT_W'($urandom_range(2, 64)), 7, 7, 250);
        test_random_phase(11'd1025, 0,  0,  200);
        test_output_backpressure();

        wait_idle();
        $display("Run covered %0d updates and %0d queries, %0d of them with a bad range;",
                 n_updates, n_queries, n_bad_range);
        $display("%0d results checked over counts 0 to 2047, four idling patterns and a hold-off.",
                 n_checked);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: many times the slowest correct run.
    initial begin
        #20_000_000;
        $display("Timed out with %0d answers still pending.", pending_answers.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
design/rtst_pkg.sv
design/rtst_ram.sv
design/rtst_ctrl.sv
design/rtst_dp.sv
design/range_top_two_sum_tree_core.sv
test/range_top_two_sum_tree_core_tb.sv
